// ===== hw/rtl/pif_pkg.sv =====
package pif_pkg;

  localparam int MAX_DIGITS_DEF = 16;
  localparam int MAX_WIDTH_DEF = 62;
  localparam int FW_BITS = 6;

  localparam logic [15:0] CH_NUL = 16'h0000;
  localparam logic [15:0] CH_PCT = 16'h0025;
  localparam logic [15:0] CH_ZERO = 16'h0030;
  localparam logic [15:0] CH_ONE = 16'h0031;
  localparam logic [15:0] CH_NINE = 16'h0039;
  localparam logic [15:0] CH_LA = 16'h0061;
  localparam logic [15:0] CH_MINUS = 16'h002d;
  localparam logic [15:0] CH_PLUS = 16'h002b;
  localparam logic [15:0] CH_HASH = 16'h0023;
  localparam logic [15:0] CH_LX = 16'h0078;
  localparam logic [15:0] CH_UX = 16'h0058;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_LD = 16'h0064;
  localparam logic [15:0] CH_LI = 16'h0069;
  localparam logic [15:0] CH_LU = 16'h0075;
  localparam logic [15:0] CH_LO = 16'h006f;
  localparam logic [15:0] CH_LP = 16'h0070;
  localparam logic [15:0] CH_LC = 16'h0063;
  localparam logic [15:0] CH_LF = 16'h0066;
  localparam logic [15:0] CH_UF = 16'h0046;

  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_FLAGS = 2'd1;
  localparam logic [1:0] MODE_WIDTH = 2'd2;

  typedef struct packed {
    logic [15:0] format_char;
    logic [63:0] argument;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_char;
    logic        last_of_run;
    logic        unsupported;
    logic        string_end;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ONE, S_EXT, S_SETUP, S_PRE1, S_PRE2, S_PAD, S_DRD, S_DOUT
  } state_t;

  typedef enum logic [3:0] {
    CLS_NUL, CLS_TEXT, CLS_OPEN, CLS_WDIG, CLS_FLAG, CLS_PCT, CLS_CONV, CLS_CHAR,
    CLS_UNSUP, CLS_IGNORE
  } cls_t;

  typedef enum logic [2:0] {
    CONV_SDEC, CONV_UDEC, CONV_OCT, CONV_HEX32, CONV_HEX64
  } conv_t;

  typedef enum logic [2:0] {
    SEL_ONE, SEL_PRE1, SEL_PRE2, SEL_PAD, SEL_DIGIT
  } sel_t;

  typedef struct packed {
    logic decode;
    logic ext;
    logic setup;
    logic emit;
    sel_t sel;
    logic rd;
    logic end_dir;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic ext_done;
    logic need_pre1;
    logic need_pre2;
    logic pad_zero;
    logic idx_zero;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/pif_ram.sv =====
module pif_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/pif_ctrl.sv =====
module pif_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pif_pkg::sts_t sts,
  output pif_pkg::cmd_t cmd
);
  import pif_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.sel = SEL_ONE;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        unique case (sts.cls)
          CLS_NUL, CLS_TEXT, CLS_PCT, CLS_CHAR, CLS_UNSUP: state_nxt = S_ONE;
          CLS_CONV: state_nxt = S_EXT;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ONE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel = SEL_ONE;
          state_nxt = S_IDLE;
        end
      end
      S_EXT: begin
        cmd.ext = 1'b1;
        if (sts.ext_done) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        priority if (sts.need_pre1) state_nxt = S_PRE1;
        else if (sts.need_pre2) state_nxt = S_PRE2;
        else state_nxt = S_PAD;
      end
      S_PRE1: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel = SEL_PRE1;
          state_nxt = sts.need_pre2 ? S_PRE2 : S_PAD;
        end
      end
      S_PRE2: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel = SEL_PRE2;
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        priority if (sts.pad_zero) begin
          state_nxt = S_DRD;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel = SEL_PAD;
        end
      end
      S_DRD: begin
        cmd.rd = 1'b1;
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel = SEL_DIGIT;
          if (sts.idx_zero) begin
            cmd.end_dir = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && in_valid |=> state_r == S_DECODE)
    else $error("accepted word not decoded");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("emit into a full output register");
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.end_dir |-> cmd.emit && sts.idx_zero)
    else $error("directive closed before last digit");

endmodule

// ===== hw/rtl/pif_dp.sv =====
module pif_dp #(
  parameter int MAX_DIGITS = pif_pkg::MAX_DIGITS_DEF,
  parameter int MAX_WIDTH = pif_pkg::MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  pif_pkg::in_word_t    in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pif_pkg::out_word_t   out_word,
  input  pif_pkg::cmd_t        cmd,
  output pif_pkg::sts_t        sts
);
  import pif_pkg::*;

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int PW = (CW > FW_BITS) ? CW + 1 : FW_BITS + 1;

  logic [15:0] c_r;
  logic [63:0] arg_r;
  cls_t cls_now, cls_r;
  conv_t conv_r;
  logic [1:0] mode_r;
  logic force_r, zpad_r, pfx_r, wgiven_r;
  logic [FW_BITS-1:0] fw_r;
  logic neg_r;
  logic [63:0] v_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] idx_r;
  logic [FW_BITS-1:0] pad_r;
  logic out_valid_r;
  out_word_t out_word_r;

  logic [31:0] lo;
  logic [9:0] fw_mul;
  logic [FW_BITS-1:0] fw_sat;
  logic [63:0] prod;
  logic [31:0] q10;
  logic [3:0] r10;
  logic [63:0] q;
  logic [3:0] dig;
  logic [PW-1:0] fw_ext, cnt_ext;
  logic [3:0] rd_dig;
  logic [15:0] dig_char;
  logic out_free;
  logic is_hex;
  out_word_t emit_word;

  assign lo = arg_r[31:0];

  always_comb begin
    priority if (c_r == CH_NUL) cls_now = CLS_NUL;
    else if (mode_r == MODE_TEXT) cls_now = (c_r == CH_PCT) ? CLS_OPEN : CLS_TEXT;
    else if (c_r >= CH_ONE && c_r <= CH_NINE) cls_now = CLS_WDIG;
    else begin
      unique case (c_r)
        CH_PCT: cls_now = CLS_PCT;
        CH_PLUS, CH_HASH, CH_ZERO: cls_now = CLS_FLAG;
        CH_LD, CH_LI, CH_LU, CH_LO, CH_LX, CH_UX, CH_LP: cls_now = CLS_CONV;
        CH_LC: cls_now = CLS_CHAR;
        CH_LF, CH_UF: cls_now = CLS_UNSUP;
        default: cls_now = CLS_IGNORE;
      endcase
    end
  end

  always_comb begin
    fw_mul = 10'({4'd0, fw_r} * 10) + {6'd0, c_r[3:0]};
    fw_sat = (fw_mul > 10'(MAX_WIDTH)) ? FW_BITS'(MAX_WIDTH) : fw_mul[FW_BITS-1:0];
  end

  always_comb begin
    prod = {32'd0, v_r[31:0]} * 64'h0000_0000_CCCC_CCCD;
    q10 = {3'd0, prod[63:35]};
    r10 = 4'(v_r[31:0] - ((q10 << 3) + (q10 << 1)));
    unique case (conv_r)
      CONV_SDEC, CONV_UDEC: begin
        q = {32'd0, q10};
        dig = r10;
      end
      CONV_OCT: begin
        q = v_r >> 3;
        dig = {1'b0, v_r[2:0]};
      end
      default: begin
        q = v_r >> 4;
        dig = v_r[3:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      c_r <= in_word.format_char;
      arg_r <= in_word.argument;
    end
    if (cmd.decode) begin
      cls_r <= cls_now;
      cnt_r <= '0;
      neg_r <= lo[31];
      unique case (c_r)
        CH_LD, CH_LI: begin
          conv_r <= CONV_SDEC;
          v_r <= {32'd0, lo[31] ? (32'd0 - lo) : lo};
        end
        CH_LU: begin
          conv_r <= CONV_UDEC;
          v_r <= {32'd0, lo};
        end
        CH_LO: begin
          conv_r <= CONV_OCT;
          v_r <= {32'd0, lo};
        end
        CH_LP: begin
          conv_r <= CONV_HEX64;
          v_r <= arg_r;
        end
        default: begin
          conv_r <= CONV_HEX32;
          v_r <= {32'd0, lo};
        end
      endcase
    end
    if (cmd.ext) begin
      v_r <= q;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.setup) begin
      pad_r <= (wgiven_r && fw_ext > cnt_ext) ? FW_BITS'(fw_ext - cnt_ext) : '0;
      idx_r <= AW'(cnt_r - 1'b1);
    end
    if (cmd.emit && cmd.sel == SEL_PAD) pad_r <= pad_r - 1'b1;
    if (cmd.emit && cmd.sel == SEL_DIGIT) idx_r <= idx_r - 1'b1;
    if (cmd.emit) out_word_r <= emit_word;
  end

  assign fw_ext = PW'(fw_r);
  assign cnt_ext = PW'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TEXT;
      force_r <= 1'b0;
      zpad_r <= 1'b0;
      pfx_r <= 1'b0;
      wgiven_r <= 1'b0;
      fw_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      priority if (cmd.end_dir || (cmd.decode && (cls_now == CLS_NUL ||
          cls_now == CLS_PCT || cls_now == CLS_CHAR || cls_now == CLS_UNSUP))) begin
        mode_r <= MODE_TEXT;
        force_r <= 1'b0;
        zpad_r <= 1'b0;
        pfx_r <= 1'b0;
        wgiven_r <= 1'b0;
        fw_r <= '0;
      end else if (cmd.decode) begin
        unique case (cls_now)
          CLS_OPEN: mode_r <= MODE_FLAGS;
          CLS_WDIG: begin
            mode_r <= MODE_WIDTH;
            wgiven_r <= 1'b1;
            fw_r <= fw_sat;
          end
          CLS_FLAG: begin
            priority if (c_r == CH_PLUS) force_r <= 1'b1;
            else if (c_r == CH_HASH) pfx_r <= 1'b1;
            else if (mode_r == MODE_FLAGS) zpad_r <= 1'b1;
            else fw_r <= fw_sat;
          end
          default: ;
        endcase
      end
    end
  end

  pif_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_digits (
    .clk   (clk),
    .we    (cmd.ext),
    .waddr (cnt_r[AW-1:0]),
    .wdata (dig),
    .re    (cmd.rd),
    .raddr (idx_r),
    .rdata (rd_dig)
  );

  assign dig_char = (rd_dig < 4'd10) ? CH_ZERO + 16'(rd_dig)
                                     : CH_LA + 16'(rd_dig) - 16'd10;
  assign is_hex = (conv_r == CONV_HEX32) || (conv_r == CONV_HEX64);

  always_comb begin
    emit_word = '0;
    unique case (cmd.sel)
      SEL_ONE: begin
        emit_word.last_of_run = 1'b1;
        unique case (cls_r)
          CLS_NUL: emit_word.string_end = 1'b1;
          CLS_PCT: emit_word.out_char = CH_PCT;
          CLS_CHAR: emit_word.out_char = lo[15:0];
          CLS_UNSUP: emit_word.unsupported = 1'b1;
          default: emit_word.out_char = c_r;
        endcase
      end
      SEL_PRE1: emit_word.out_char = is_hex ? CH_ZERO : (neg_r ? CH_MINUS : CH_PLUS);
      SEL_PRE2: emit_word.out_char = CH_LX;
      SEL_PAD: emit_word.out_char = zpad_r ? CH_ZERO : CH_SPACE;
      SEL_DIGIT: begin
        emit_word.out_char = dig_char;
        emit_word.last_of_run = (idx_r == '0);
      end
      default: ;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

  always_comb begin
    sts.cls = cls_now;
    sts.ext_done = (q == 64'd0) || (cnt_r == CW'(MAX_DIGITS - 1));
    sts.need_pre1 = (conv_r == CONV_SDEC && (neg_r || force_r)) || (is_hex && pfx_r);
    sts.need_pre2 = is_hex && pfx_r;
    sts.pad_zero = (pad_r == '0);
    sts.idx_zero = (idx_r == '0);
    sts.out_free = out_free;
  end

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_word_r.string_end || out_word_r.unsupported)
      |-> out_word_r.last_of_run)
    else $error("terminating word not last");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ext |-> cnt_r < CW'(MAX_DIGITS))
    else $error("digit store overrun");
  a_fw_range: assert property (@(posedge clk) disable iff (!rst_n)
    fw_r <= FW_BITS'(MAX_WIDTH))
    else $error("field width over limit");

endmodule

// ===== hw/rtl/printf_integer_formatter.sv =====
// channel | ports                             | word
// input   | in_valid, in_ready, in_word       | format_char, argument
// output  | out_valid, out_ready, out_word    | out_char, last_of_run, unsupported, string_end
// one format word at a time; a text or single-character word passes the idle, decode and one-word states
// a conversion runs one extract step per digit (shared divide-by-base unit), then a setup step,
// plus prefix and pad words, one per cycle while the output is free, and a store read per digit
// synchronous active-low reset clears the parser flags, width and output valid
// a stalled output holds the word in its register; extraction is not held by stalls
module printf_integer_formatter #(
  parameter int MAX_DIGITS = pif_pkg::MAX_DIGITS_DEF,
  parameter int MAX_WIDTH = pif_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pif_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output pif_pkg::out_word_t out_word
);
  import pif_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pif_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pif_dp #(.MAX_DIGITS(MAX_DIGITS), .MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
